// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AVCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An antecedent that, when true, forces the consequent in the next cycle.
`define AVCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/avcc_pkg.sv -----
// ----------------------------------------------------------------------------
// AVC configuration record parser package
// Result kinds, burst types and the Annex B start code.
// ----------------------------------------------------------------------------
package avcc_pkg;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Index 0 is the first byte sent.
  localparam logic [3:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

  typedef enum logic [1:0] {
    BURST_HDR,
    BURST_SC,
    BURST_DATA,
    BURST_ERR
  } burst_e;

endpackage

// ----- rtl/avc_config_record_to_annexb_core.sv -----
// ----------------------------------------------------------------------------
// AVC configuration record to Annex B converter
// Parses a decoder configuration record byte by byte, reports the header and
// emits each parameter set with a start code in front of it; a record that ends early gives an error result.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  input   | in_valid_i, in_stall_o, payload | into block
//  output  | out_valid_o, out_stall_i, fields| from block
//
// Each byte updates the parse state in the cycle it is accepted. Its results
// are loaded into one output burst register and leave one per cycle while
// out_stall_i is low. Every byte waits while an earlier burst still has more
// than its final result to deliver; the final result and the next byte pass
// in the same cycle. The low length byte gives four or five results, and the
// byte after it is held until the last of them is taken. Reset (rst_ni low)
// returns to the first header byte and drops any pending burst; no clearing
// pass is needed.
module avc_config_record_to_annexb_core
  import avcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       set_type_o,
  output logic [7:0] set_index_o,
  output logic       first_of_set_o,
  output logic       last_of_set_o,
  output logic       last_o,
  output logic [7:0] version_o,
  output logic [7:0] profile_o,
  output logic [7:0] compat_o,
  output logic [7:0] level_o,
  output logic [1:0] len_size_minus_one_o
);

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_SPSN = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_PPSN = 3'd5;
  localparam logic [2:0] PH_TAIL = 3'd6;

  // Parse state.
  logic [2:0]       phase_q, phase_d;
  logic [3:0][7:0]  hdr_q, hdr_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [7:0]       sets_left_q, sets_left_d;
  logic [7:0]       set_num_q, set_num_d;
  logic [15:0]      bytes_left_q, bytes_left_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic             in_pps_q, in_pps_d;

  // Output burst.
  logic             bv_q;
  burst_e           burst_q, burst_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [2:0]       pos_q;
  logic             err_q, err_d;
  logic [7:0]       byte_q, byte_d;
  logic             type_q, type_d;
  logic [7:0]       idx_q, idx_d;
  logic             lastset_q, lastset_d;
  logic [3:0][7:0]  hv_q;
  logic [1:0]       lsize_q, lsize_d;

  logic             in_acc, out_acc, burst_end, load;
  logic [2:0]       nbase;

  assign burst_end  = (pos_q == cnt_q - 3'd1);
  assign out_acc    = bv_q && !out_stall_i;
  assign in_stall_o = bv_q && !(out_acc && burst_end);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load       = in_acc && ((nbase != 3'd0) || err_d);

  always_comb begin
    logic [7:0]  sl_dec;
    logic [15:0] bl_new;
    phase_d      = phase_q;
    hdr_d        = hdr_q;
    hcnt_d       = hcnt_q;
    sets_left_d  = sets_left_q;
    set_num_d    = set_num_q;
    bytes_left_d = bytes_left_q;
    len_hi_d     = len_hi_q;
    in_pps_d     = in_pps_q;
    nbase        = 3'd0;
    burst_d      = BURST_ERR;
    byte_d       = in_byte_i;
    type_d       = in_pps_q;
    idx_d        = set_num_q;
    lastset_d    = 1'b0;
    lsize_d      = in_byte_i[1:0];
    sl_dec       = sets_left_q - 8'd1;
    bl_new       = bytes_left_q - 16'd1;

    unique case (phase_q)
      PH_HDR: begin
        if (hcnt_q < 3'd4) begin
          hdr_d[hcnt_q[1:0]] = in_byte_i;
          hcnt_d             = hcnt_q + 3'd1;
        end else begin
          nbase   = 3'd1;
          burst_d = BURST_HDR;
          hcnt_d  = 3'd0;
          phase_d = PH_SPSN;
        end
      end
      PH_SPSN: begin
        in_pps_d    = 1'b0;
        sets_left_d = {3'd0, in_byte_i[4:0]};
        set_num_d   = 8'd0;
        phase_d     = (in_byte_i[4:0] != 5'd0) ? PH_LENH : PH_PPSN;
      end
      PH_LENH: begin
        len_hi_d = in_byte_i;
        phase_d  = PH_LENL;
      end
      PH_LENL: begin
        bytes_left_d = {len_hi_q, in_byte_i};
        nbase        = 3'd4;
        burst_d      = BURST_SC;
        lastset_d    = ({len_hi_q, in_byte_i} == 16'd0);
        if (lastset_d) begin
          sets_left_d = sl_dec;
          set_num_d   = set_num_q + 8'd1;
          phase_d     = (sl_dec != 8'd0) ? PH_LENH : (in_pps_q ? PH_TAIL : PH_PPSN);
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_left_d = bl_new;
        nbase        = 3'd1;
        burst_d      = BURST_DATA;
        lastset_d    = (bl_new == 16'd0);
        if (lastset_d) begin
          sets_left_d = sl_dec;
          set_num_d   = set_num_q + 8'd1;
          phase_d     = (sl_dec != 8'd0) ? PH_LENH : (in_pps_q ? PH_TAIL : PH_PPSN);
        end
      end
      PH_PPSN: begin
        in_pps_d    = 1'b1;
        sets_left_d = in_byte_i;
        set_num_d   = 8'd0;
        phase_d     = (in_byte_i != 8'd0) ? PH_LENH : PH_TAIL;
      end
      default: begin
        phase_d = PH_TAIL;
      end
    endcase

    err_d = last_in_i && (phase_d != PH_TAIL);
    cnt_d = nbase + {2'd0, err_d};

    // The end of a record puts the parse state, apart from the header bytes, back to its start.
    if (last_in_i) begin
      phase_d      = PH_HDR;
      hcnt_d       = 3'd0;
      sets_left_d  = 8'd0;
      set_num_d    = 8'd0;
      bytes_left_d = 16'd0;
      len_hi_d     = 8'd0;
      in_pps_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      hcnt_q       <= 3'd0;
      sets_left_q  <= 8'd0;
      set_num_q    <= 8'd0;
      bytes_left_q <= 16'd0;
      len_hi_q     <= 8'd0;
      in_pps_q     <= 1'b0;
      bv_q         <= 1'b0;
      pos_q        <= 3'd0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        hcnt_q       <= hcnt_d;
        sets_left_q  <= sets_left_d;
        set_num_q    <= set_num_d;
        bytes_left_q <= bytes_left_d;
        len_hi_q     <= len_hi_d;
        in_pps_q     <= in_pps_d;
      end
      if (load) begin
        bv_q  <= 1'b1;
        pos_q <= 3'd0;
      end else if (out_acc) begin
        if (burst_end) begin
          bv_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  // Header bytes and burst payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hdr_q <= hdr_d;
    end
    if (load) begin
      burst_q   <= burst_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      byte_q    <= byte_d;
      type_q    <= type_d;
      idx_q     <= idx_d;
      lastset_q <= lastset_d;
      hv_q      <= hdr_q;
      lsize_q   <= lsize_d;
    end
  end

  assign out_valid_o = bv_q;

  always_comb begin
    kind_o               = KIND_ERR;
    data_byte_o          = 8'd0;
    set_type_o           = 1'b0;
    set_index_o          = 8'd0;
    first_of_set_o       = 1'b0;
    last_of_set_o        = 1'b0;
    last_o               = burst_end;
    version_o            = 8'd0;
    profile_o            = 8'd0;
    compat_o             = 8'd0;
    level_o              = 8'd0;
    len_size_minus_one_o = 2'd0;
    // A trailing error result takes the last slot of the burst.
    if (!(err_q && burst_end)) begin
      unique case (burst_q)
        BURST_HDR: begin
          kind_o               = KIND_HDR;
          version_o            = hv_q[0];
          profile_o            = hv_q[1];
          compat_o             = hv_q[2];
          level_o              = hv_q[3];
          len_size_minus_one_o = lsize_q;
        end
        BURST_SC: begin
          kind_o         = KIND_SET;
          data_byte_o    = START_CODE[pos_q[1:0]];
          set_type_o     = type_q;
          set_index_o    = idx_q;
          first_of_set_o = (pos_q == 3'd0);
          last_of_set_o  = lastset_q && (pos_q == 3'd3);
        end
        BURST_DATA: begin
          kind_o        = KIND_SET;
          data_byte_o   = byte_q;
          set_type_o    = type_q;
          set_index_o   = idx_q;
          last_of_set_o = lastset_q;
        end
        default: begin
          kind_o = KIND_ERR;
        end
      endcase
    end
  end

endmodule

// ----- rtl/avcc_checker.sv -----
// ----------------------------------------------------------------------------
// AVC configuration record converter checker
// Port-level assertions, bound to the converter top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avcc_checker
  import avcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       first_of_set_o,
  input logic       last_o
);

  // A stalled transaction keeps its data byte and kind.
  `AVCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(data_byte_o), "stalled result changed")

  // An error result always closes the results of its input byte.
  `AVCC_ASSERT(a_err_last, clk_i, rst_ni, !(out_valid_o && kind_o == KIND_ERR) || last_o,
    "error result without last")

  // A set opens with a zero start code byte.
  `AVCC_ASSERT(a_first, clk_i, rst_ni, !(out_valid_o && first_of_set_o) ||
    (kind_o == KIND_SET && data_byte_o == 8'd0 && !last_o), "bad first byte of set")

  // After a first start code byte the next result continues the same set.
  `AVCC_ASSERT_NEXT(a_follow, clk_i, rst_ni, out_valid_o && !out_stall_i && first_of_set_o,
    out_valid_o && (kind_o == KIND_SET || kind_o == KIND_ERR) && !first_of_set_o,
    "start code broken up")

endmodule

bind avc_config_record_to_annexb_core avcc_checker u_avcc_checker (.*);
